/* hw/rtl/vfc_pkg.sv */
// Shared types and constants for the six-plane frustum cull test.
`default_nettype none

package vfc_pkg;

	localparam int NUM_PLANES = 6;
	localparam int EXT_W      = 23;
	localparam int DIST_W     = 28;
	localparam int PLANE_W    = 64;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	typedef enum logic [1:0] {
		MODE_POINT  = 2'd0,
		MODE_SPHERE = 2'd1,
		MODE_CUBE   = 2'd2,
		MODE_POLY   = 2'd3
	} vfc_mode_t;

	typedef enum logic [1:0] {
		VERDICT_OUT  = 2'd0,
		VERDICT_PART = 2'd1,
		VERDICT_IN   = 2'd2
	} vfc_verdict_t;

	// item control and the running per-plane tallies that ride with it
	typedef struct packed {
		vfc_mode_t        mode;
		logic             last;
		logic [EXT_W-1:0] ext;
		logic             pt_in;    // every plane so far has d > 0
		logic             outside;  // some plane so far rejects the volume
		logic             full;     // every plane so far fully contains it
		logic             poly_all; // every polygon flag so far is set
	} vfc_info_t;

endpackage

`default_nettype wire

/* hw/rtl/vfc_cell.sv */
// One plane cell: distance to its plane, tally update, polygon flag for its plane.
`default_nettype none

module vfc_cell #(
	parameter int COORD_WIDTH = 24,
	parameter int DW          = 39
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [63:0]                plane,
	input  logic                       up_valid,
	output logic                       up_ready,
	input  vfc_pkg::vfc_info_t         up_info,
	input  logic [COORD_WIDTH-1:0]     up_x,
	input  logic [COORD_WIDTH-1:0]     up_y,
	input  logic [COORD_WIDTH-1:0]     up_z,
	input  logic [DW-2:0]              up_dmax,
	output logic                       dn_valid,
	input  logic                       dn_ready,
	output vfc_pkg::vfc_info_t         dn_info,
	output logic [COORD_WIDTH-1:0]     dn_x,
	output logic [COORD_WIDTH-1:0]     dn_y,
	output logic [COORD_WIDTH-1:0]     dn_z,
	output logic [DW-2:0]              dn_dmax
);
	import vfc_pkg::*;

	localparam int PW = COORD_WIDTH + 12;
	localparam int TW = EXT_W + 13;

	// plane fields
	logic signed [11:0] na, nb, nc;
	logic signed [27:0] noff;
	logic [11:0]        a_abs, b_abs, c_abs;
	logic [12:0]        asum;

	assign na   = plane[11:0];
	assign nb   = plane[23:12];
	assign nc   = plane[35:24];
	assign noff = plane[63:36];

	assign a_abs = na[11] ? 12'(-na) : na;
	assign b_abs = nb[11] ? 12'(-nb) : nb;
	assign c_abs = nc[11] ? 12'(-nc) : nc;
	assign asum  = 13'(a_abs) + 13'(b_abs) + 13'(c_abs);

	logic signed [PW-1:0] a_w, b_w, c_w, x_w, y_w, z_w;
	assign a_w = {{(PW-12){na[11]}}, na};
	assign b_w = {{(PW-12){nb[11]}}, nb};
	assign c_w = {{(PW-12){nc[11]}}, nc};
	assign x_w = {{12{up_x[COORD_WIDTH-1]}}, up_x};
	assign y_w = {{12{up_y[COORD_WIDTH-1]}}, up_y};
	assign z_w = {{12{up_z[COORD_WIDTH-1]}}, up_z};

	logic [TW-1:0] thr;
	always_comb begin
		if (up_info.mode == MODE_SPHERE) begin
			thr = {3'b000, up_info.ext, 10'b0};
		end else begin
			thr = TW'(up_info.ext) * TW'(asum);
		end
	end

	// stage 1: products and threshold
	logic                     v_s1;
	vfc_info_t                info_s1;
	logic [COORD_WIDTH-1:0]   x_s1, y_s1, z_s1;
	logic [DW-2:0]            dmax_s1;
	logic signed [PW-1:0]     pa_s1, pb_s1, pc_s1;
	logic [TW-1:0]            thr_s1;

	// stage 2: tallies after this plane
	logic                     v_s2;
	vfc_info_t                info_s2;
	logic [COORD_WIDTH-1:0]   x_s2, y_s2, z_s2;
	logic [DW-2:0]            dmax_s2;
	logic                     flag_q;

	logic en1, en2;
	assign en2      = !v_s2 || dn_ready;
	assign en1      = !v_s1 || en2;
	assign up_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && up_valid) begin
			info_s1 <= up_info;
			x_s1    <= up_x;
			y_s1    <= up_y;
			z_s1    <= up_z;
			dmax_s1 <= up_dmax;
			pa_s1   <= a_w * x_w;
			pb_s1   <= b_w * y_w;
			pc_s1   <= c_w * z_w;
			thr_s1  <= thr;
		end
	end

	// distance and compares on stage 1 contents
	logic signed [DW-1:0] pdist, thr_p, thr_n;
	logic                 pos, flag_nxt;
	vfc_info_t            info_nxt;
	logic [DW-2:0]        dmax_nxt;

	always_comb begin
		pdist = {{(DW-PW){pa_s1[PW-1]}}, pa_s1}
		      + {{(DW-PW){pb_s1[PW-1]}}, pb_s1}
		      + {{(DW-PW){pc_s1[PW-1]}}, pc_s1}
		      + {{(DW-38){noff[27]}}, noff, 10'b0};
		thr_p = {{(DW-TW){1'b0}}, thr_s1};
		thr_n = -thr_p;
		pos   = pdist > 0;

		info_nxt          = info_s1;
		info_nxt.pt_in    = info_s1.pt_in && pos;
		info_nxt.outside  = info_s1.outside || (pdist <= thr_n);
		info_nxt.full     = info_s1.full && (pdist > thr_p);

		flag_nxt          = flag_q || pos;
		info_nxt.poly_all = info_s1.poly_all && flag_nxt;

		dmax_nxt = dmax_s1;
		if (pos && (pdist > $signed({1'b0, dmax_s1}))) begin
			dmax_nxt = pdist[DW-2:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2   <= 1'b0;
			flag_q <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
			// clear the polygon flag once its last vertex has passed
			if (v_s1 && info_s1.mode == MODE_POLY) begin
				flag_q <= info_s1.last ? 1'b0 : flag_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			info_s2 <= info_nxt;
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			z_s2    <= z_s1;
			dmax_s2 <= dmax_nxt;
		end
	end

	assign dn_valid = v_s2;
	assign dn_info  = info_s2;
	assign dn_x     = x_s2;
	assign dn_y     = y_s2;
	assign dn_z     = z_s2;
	assign dn_dmax  = dmax_s2;

endmodule

`default_nettype wire

/* hw/rtl/vfc_out.sv */
// Result stage: verdict, sphere distance with saturation, output register.
`default_nettype none

module vfc_out #(
	parameter int DW = 39
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        up_valid,
	output logic                        up_ready,
	input  vfc_pkg::vfc_info_t          up_info,
	input  logic [DW-2:0]               up_dmax,
	output logic                        res_valid,
	input  logic                        res_ready,
	output vfc_pkg::vfc_verdict_t       res_verdict,
	output logic [vfc_pkg::DIST_W-1:0]  res_dist
);
	import vfc_pkg::*;

	localparam int QW = DW - 11;
	localparam int SW = (QW > EXT_W ? QW : EXT_W) + 1;

	logic         ov_q;
	vfc_verdict_t verdict_q;
	logic [DIST_W-1:0] dist_q;

	logic en;
	assign en       = !ov_q || res_ready;
	assign up_ready = en;

	logic [SW-1:0]     dsum;
	logic [DIST_W-1:0] dsat;
	vfc_verdict_t      verdict;
	logic [DIST_W-1:0] dist_res;
	logic              emit;

	always_comb begin
		dsum = SW'(up_dmax[DW-2:10]) + SW'(up_info.ext);
		dsat = (dsum > {{(SW-DIST_W){1'b0}}, DIST_MAX}) ? DIST_MAX : dsum[DIST_W-1:0];
		dist_res = '0;
		unique case (up_info.mode)
			MODE_POINT: begin
				verdict = up_info.pt_in ? VERDICT_IN : VERDICT_OUT;
			end
			MODE_SPHERE, MODE_CUBE: begin
				if (up_info.outside) begin
					verdict = VERDICT_OUT;
				end else begin
					verdict = up_info.full ? VERDICT_IN : VERDICT_PART;
					if (up_info.mode == MODE_SPHERE) begin
						dist_res = dsat;
					end
				end
			end
			MODE_POLY: begin
				verdict = up_info.poly_all ? VERDICT_PART : VERDICT_OUT;
			end
			default: begin
				verdict = VERDICT_OUT;
			end
		endcase
		// drop vertices other than the last one of a polygon
		emit = up_valid && !(up_info.mode == MODE_POLY && !up_info.last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (en) begin
			ov_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (en && emit) begin
			verdict_q <= verdict;
			dist_q    <= dist_res;
		end
	end

	assign res_valid   = ov_q;
	assign res_verdict = verdict_q;
	assign res_dist    = dist_q;

endmodule

`default_nettype wire

/* hw/rtl/view_frustum_cull_test.sv */
// Top level: plane registers, chain of six plane cells, result stage.
//
//  channel   dir  handshake            content
//  s_*       in   s_tvalid / s_tready  primitive: position, extent, mode, last vertex
//  m_*       out  m_tvalid / m_tready  verdict and sphere distance
//  APB       in   psel,penable,pready  six 64-bit plane registers at 8*i
//
// One primitive per clock while m_tready keeps the output moving. The pipeline has
// two register stages in each of the six plane cells (products, then distance and
// tally) and the output register. Each stage has its own valid bit and stalls only
// when the stage below it holds data that is not taken, so bubbles close up under
// back pressure. Reset clears valid bits, polygon flags and plane registers.
`default_nettype none

module view_frustum_cull_test #(
	parameter int COORD_WIDTH = 24,
	localparam int S_TDATA_W  = ((3 * COORD_WIDTH + 23 + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [5:0]            paddr,
	input  logic [63:0]           pwdata,
	output logic [63:0]           prdata,
	output logic                  pready,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// pos_x, pos_y, pos_z, extent, zero fill
	input  logic [S_TDATA_W-1:0]  s_tdata,
	// mode
	input  logic [1:0]            s_tuser,
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// verdict, sphere_distance, zero fill
	output logic [31:0]           m_tdata
);
	import vfc_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int DM = (CW + 12 > 37) ? CW + 12 : 37;
	localparam int DW = DM + 2;

	// configuration
	logic [PLANE_W-1:0] plane_q [NUM_PLANES];
	logic [2:0]         reg_idx;

	assign reg_idx = paddr[5:3];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PLANES; i++) begin
				plane_q[i] <= '0;
			end
		end else if (psel && penable && pwrite && pready) begin
			for (int i = 0; i < NUM_PLANES; i++) begin
				if (reg_idx == 3'(i)) begin
					plane_q[i] <= pwdata;
				end
			end
		end
	end

	always_comb begin
		prdata = '0;
		for (int i = 0; i < NUM_PLANES; i++) begin
			if (reg_idx == 3'(i)) begin
				prdata = plane_q[i];
			end
		end
	end

	// cell chain
	logic              c_valid [NUM_PLANES+1];
	logic              c_ready [NUM_PLANES+1];
	vfc_info_t         c_info  [NUM_PLANES+1];
	logic [CW-1:0]     c_x     [NUM_PLANES+1];
	logic [CW-1:0]     c_y     [NUM_PLANES+1];
	logic [CW-1:0]     c_z     [NUM_PLANES+1];
	logic [DW-2:0]     c_dmax  [NUM_PLANES+1];

	always_comb begin
		c_info[0]          = '0;
		c_info[0].mode     = vfc_mode_t'(s_tuser);
		c_info[0].last     = s_tlast;
		c_info[0].ext      = s_tdata[3*CW+EXT_W-1:3*CW];
		c_info[0].pt_in    = 1'b1;
		c_info[0].outside  = 1'b0;
		c_info[0].full     = 1'b1;
		c_info[0].poly_all = 1'b1;
	end

	assign c_valid[0] = s_tvalid;
	assign s_tready   = c_ready[0];
	assign c_x[0]     = s_tdata[CW-1:0];
	assign c_y[0]     = s_tdata[2*CW-1:CW];
	assign c_z[0]     = s_tdata[3*CW-1:2*CW];
	assign c_dmax[0]  = '0;

	for (genvar g = 0; g < NUM_PLANES; g++) begin : g_cell
		vfc_cell #(
			.COORD_WIDTH (CW),
			.DW          (DW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.plane    (plane_q[g]),
			.up_valid (c_valid[g]),
			.up_ready (c_ready[g]),
			.up_info  (c_info[g]),
			.up_x     (c_x[g]),
			.up_y     (c_y[g]),
			.up_z     (c_z[g]),
			.up_dmax  (c_dmax[g]),
			.dn_valid (c_valid[g+1]),
			.dn_ready (c_ready[g+1]),
			.dn_info  (c_info[g+1]),
			.dn_x     (c_x[g+1]),
			.dn_y     (c_y[g+1]),
			.dn_z     (c_z[g+1]),
			.dn_dmax  (c_dmax[g+1])
		);
	end

	vfc_verdict_t      res_verdict;
	logic [DIST_W-1:0] res_dist;

	vfc_out #(
		.DW (DW)
	) u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.up_valid    (c_valid[NUM_PLANES]),
		.up_ready    (c_ready[NUM_PLANES]),
		.up_info     (c_info[NUM_PLANES]),
		.up_dmax     (c_dmax[NUM_PLANES]),
		.res_valid   (m_tvalid),
		.res_ready   (m_tready),
		.res_verdict (res_verdict),
		.res_dist    (res_dist)
	);

	assign m_tdata = {2'b00, res_dist, res_verdict};

endmodule

`default_nettype wire

/* verif/tb_view_frustum_cull_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the six-plane view frustum cull test block.
module tb_view_frustum_cull_test;
	import vfc_pkg::*;

	localparam int COORD_W      = 24;
	localparam int S_TDATA_W    = 96;
	localparam int Q_ONE        = 1024;
	localparam int PLANE_STRIDE = 8;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int LOG_CAP      = 100;
	localparam int BOX_H        = 'h1000;

	typedef enum int {
		PLANE_LEFT, PLANE_RIGHT, PLANE_BOTTOM, PLANE_TOP, PLANE_NEAR, PLANE_FAR
	} plane_sel_t;

	typedef struct packed {
		vfc_mode_t          mode;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic [EXT_W-1:0]   ext;
		logic               last;
	} cull_prim_t;

	typedef struct packed {
		vfc_verdict_t      verdict;
		logic [DIST_W-1:0] distance;
	} cull_verdict_t;

	class cull_scoreboard;
		logic [PLANE_W-1:0]    planes [NUM_PLANES];
		logic [NUM_PLANES-1:0] vertex_flags;
		cull_verdict_t         due [$];
		int                    errors;
		int                    results_seen;

		function new();
			int i;
			for (i = 0; i < NUM_PLANES; i++)
				planes[i] = '0;
			vertex_flags = '0;
			errors = 0;
			results_seen = 0;
		endfunction

		function void set_plane(int idx, logic [PLANE_W-1:0] val);
			planes[idx] = val;
		endfunction

		function int pending();
			return due.size();
		endfunction

		// signed distance with 10 fraction bits, exact
		function longint plane_distance(int i, longint x, longint y, longint z);
			logic signed [11:0] na, nb, nc;
			logic signed [27:0] noff;
			longint a, b, c, off;
			na = planes[i][11:0];
			nb = planes[i][23:12];
			nc = planes[i][35:24];
			noff = planes[i][63:36];
			a = na;
			b = nb;
			c = nc;
			off = noff;
			return a * x + b * y + c * z + off * Q_ONE;
		endfunction

		function longint normal_weight(int i);
			logic signed [11:0] na, nb, nc;
			longint a, b, c;
			na = planes[i][11:0];
			nb = planes[i][23:12];
			nc = planes[i][35:24];
			a = na;
			b = nb;
			c = nc;
			return (a < 0 ? -a : a) + (b < 0 ? -b : b) + (c < 0 ? -c : c);
		endfunction

		function void note_primitive(cull_prim_t p);
			longint x, y, z, ext, d, dmax, s;
			int i, full_cnt;
			bit outside;
			cull_verdict_t r;
			x = $signed(p.x);
			y = $signed(p.y);
			z = $signed(p.z);
			ext = p.ext;
			r.verdict = VERDICT_OUT;
			r.distance = '0;
			outside = 1'b0;
			full_cnt = 0;
			dmax = 0;
			case (p.mode)
			MODE_POINT: begin
				r.verdict = VERDICT_IN;
				for (i = 0; i < NUM_PLANES; i++)
					if (plane_distance(i, x, y, z) <= 0)
						r.verdict = VERDICT_OUT;
			end
			MODE_SPHERE: begin
				for (i = 0; i < NUM_PLANES; i++) begin
					d = plane_distance(i, x, y, z);
					if (d <= -ext * Q_ONE)
						outside = 1'b1;
					if (d > ext * Q_ONE)
						full_cnt++;
					if (d > dmax)
						dmax = d;
				end
				if (!outside) begin
					s = dmax / Q_ONE + ext;
					if (s > DIST_MAX)
						s = DIST_MAX;
					r.distance = s[DIST_W-1:0];
					r.verdict = (full_cnt == NUM_PLANES) ? VERDICT_IN : VERDICT_PART;
				end
			end
			MODE_CUBE: begin
				// box reach along each normal replaces the eight corner tests
				for (i = 0; i < NUM_PLANES; i++) begin
					d = plane_distance(i, x, y, z);
					s = ext * normal_weight(i);
					if (d + s <= 0)
						outside = 1'b1;
					if (d - s > 0)
						full_cnt++;
				end
				if (!outside)
					r.verdict = (full_cnt == NUM_PLANES) ? VERDICT_IN : VERDICT_PART;
			end
			default: begin
				for (i = 0; i < NUM_PLANES; i++)
					if (plane_distance(i, x, y, z) > 0)
						vertex_flags[i] = 1'b1;
				if (!p.last)
					return;
				r.verdict = (&vertex_flags) ? VERDICT_PART : VERDICT_OUT;
				vertex_flags = '0;
			end
			endcase
			due.push_back(r);
		endfunction

		task report(string msg);
			// limit log volume, keep counting
			if (errors < LOG_CAP)
				$display("mismatch at result %0d: %s", results_seen, msg);
			errors++;
		endtask

		task check_verdict(logic [1:0] verdict, logic [DIST_W-1:0] distance);
			cull_verdict_t e;
			if (due.size() == 0) begin
				report($sformatf("unexpected verdict %0d distance %0d", verdict, distance));
			end else begin
				e = due.pop_front();
				if (verdict !== e.verdict)
					report($sformatf("verdict got %0d want %0d", verdict, e.verdict));
				if (distance !== e.distance)
					report($sformatf("distance got %0d want %0d", distance, e.distance));
			end
			results_seen++;
		endtask
	endclass

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 psel     = 1'b0;
	logic                 penable  = 1'b0;
	logic                 pwrite   = 1'b0;
	logic [5:0]           paddr    = '0;
	logic [63:0]          pwdata   = '0;
	logic [63:0]          prdata;
	logic                 pready;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	// pos_x, pos_y, pos_z, extent, zero fill
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	// mode
	logic [1:0]           s_tuser  = '0;
	logic                 s_tlast  = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	// verdict, sphere_distance, zero fill
	logic [31:0]          m_tdata;

	view_frustum_cull_test #(.COORD_WIDTH(COORD_W)) u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	cull_scoreboard sb = new();

	logic [PLANE_W-1:0] plane_cfg [NUM_PLANES];
	int                 span = BOX_H;
	int                 src_sent = 0;
	bit                 src_calm = 1'b0;
	int unsigned        cycle_cnt = 0;

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// result side: random stalls, check every transaction
	initial begin : result_sink
		int gap;
		int taken;
		bit calm;
		taken = 0;
		calm = 1'b0;
		@(posedge clk);
		forever begin
			if (taken % 32 == 0)
				calm = ($urandom_range(0, 3) == 0);
			gap = calm ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			sb.check_verdict(m_tdata[1:0], m_tdata[DIST_W+1:2]);
			taken++;
		end
	end

	// Leaves s_tvalid high on return; the caller either sends again in the
	// same step or calls hold_until_drained.
	task send(cull_prim_t p);
		int gap;
		if (src_sent % 32 == 0)
			src_calm = ($urandom_range(0, 3) == 0);
		gap = src_calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, p.ext, p.z, p.y, p.x};
		s_tuser <= p.mode;
		s_tlast <= p.last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_primitive(p);
		src_sent++;
	endtask

	task send_prim(vfc_mode_t mode, int x, int y, int z, int ext, bit last);
		cull_prim_t p;
		p.mode = mode;
		p.x = x[COORD_W-1:0];
		p.y = y[COORD_W-1:0];
		p.z = z[COORD_W-1:0];
		p.ext = ext[EXT_W-1:0];
		p.last = last;
		send(p);
	endtask

	task hold_until_drained();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		// trailing polygon vertices give no result but may still be in flight
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task write_plane(int idx, logic [PLANE_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 6'(idx * PLANE_STRIDE);
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.set_plane(idx, val);
	endtask

	task load_planes();
		int i;
		for (i = 0; i < NUM_PLANES; i++)
			write_plane(i, plane_cfg[i]);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function logic [PLANE_W-1:0] pack_plane(int a, int b, int c, int off);
		logic [PLANE_W-1:0] v;
		v = {off[27:0], c[11:0], b[11:0], a[11:0]};
		return v;
	endfunction

	function int jitter();
		int j;
		j = $urandom_range(0, 400);
		return j - 200;
	endfunction

	// axis-aligned box of half size h around the origin, normals jittered by up to 200 when tilt is set
	task set_box(int h, bit tilt);
		plane_cfg[PLANE_LEFT]   = pack_plane(Q_ONE, 0, 0, h);
		plane_cfg[PLANE_RIGHT]  = pack_plane(-Q_ONE, 0, 0, h);
		plane_cfg[PLANE_BOTTOM] = pack_plane(0, Q_ONE, 0, h);
		plane_cfg[PLANE_TOP]    = pack_plane(0, -Q_ONE, 0, h);
		plane_cfg[PLANE_NEAR]   = pack_plane(0, 0, Q_ONE, h);
		plane_cfg[PLANE_FAR]    = pack_plane(0, 0, -Q_ONE, h);
		if (tilt) begin
			plane_cfg[PLANE_LEFT]   = pack_plane(Q_ONE + jitter(), jitter(), jitter(), h);
			plane_cfg[PLANE_RIGHT]  = pack_plane(-Q_ONE - jitter(), jitter(), jitter(), h);
			plane_cfg[PLANE_BOTTOM] = pack_plane(jitter(), Q_ONE + jitter(), jitter(), h);
			plane_cfg[PLANE_TOP]    = pack_plane(jitter(), -Q_ONE - jitter(), jitter(), h);
			plane_cfg[PLANE_NEAR]   = pack_plane(jitter(), jitter(), Q_ONE + jitter(), h);
			plane_cfg[PLANE_FAR]    = pack_plane(jitter(), jitter(), -Q_ONE - jitter(), h);
		end
	endtask

	task set_uniform(logic [PLANE_W-1:0] val);
		int i;
		for (i = 0; i < NUM_PLANES; i++)
			plane_cfg[i] = val;
	endtask

	function logic [COORD_W-1:0] rand_coord();
		logic [COORD_W-1:0] v;
		if ($urandom_range(0, 9) < 7)
			v = COORD_W'($urandom_range(0, 4 * span) - 2 * span);
		else
			v = COORD_W'($urandom());
		return v;
	endfunction

	function logic [EXT_W-1:0] rand_extent();
		logic [EXT_W-1:0] v;
		case ($urandom_range(0, 3))
		0: v = '0;
		1: v = EXT_W'($urandom_range(0, span));
		2: v = EXT_W'($urandom_range(0, span / 8));
		default: v = EXT_W'($urandom());
		endcase
		return v;
	endfunction

	function cull_prim_t rand_prim(vfc_mode_t mode, bit last);
		cull_prim_t p;
		p.mode = mode;
		p.x = rand_coord();
		p.y = rand_coord();
		p.z = rand_coord();
		p.ext = rand_extent();
		p.last = last;
		return p;
	endfunction

	function vfc_mode_t pick_volume_mode();
		vfc_mode_t m;
		case ($urandom_range(0, 2))
		0: m = MODE_POINT;
		1: m = MODE_SPHERE;
		default: m = MODE_CUBE;
		endcase
		return m;
	endfunction

	task run_random(int n);
		int count, sel, nv, v;
		bit paused;
		count = 0;
		paused = 1'b0;
		while (count < n) begin
			if (!paused && count >= n / 2) begin
				hold_until_drained();
				paused = 1'b1;
			end
			sel = $urandom_range(0, 9);
			if (sel < 6) begin
				send(rand_prim(pick_volume_mode(), 1'($urandom_range(0, 1))));
				count++;
			end else if (sel < 9) begin
				// well-formed polygon, now and then broken up by other primitives
				nv = $urandom_range(1, 6);
				for (v = 0; v < nv; v++) begin
					if ($urandom_range(0, 7) == 0) begin
						send(rand_prim(pick_volume_mode(), 1'($urandom_range(0, 1))));
						count++;
					end
					send(rand_prim(MODE_POLY, v == nv - 1));
					count++;
				end
			end else begin
				// stray vertex: its flags carry into the next polygon
				send(rand_prim(MODE_POLY, 1'b0));
				count++;
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all planes zero after reset: every distance is zero
		send_prim(MODE_POINT, 0, 0, 0, 0, 1'b0);
		send_prim(MODE_SPHERE, 5, -7, 3, 'h7FFFFF, 1'b0);
		send_prim(MODE_POLY, 0, 0, 0, 0, 1'b1);
		hold_until_drained();

		span = BOX_H;
		set_box(BOX_H, 1'b0);
		load_planes();
		send_prim(MODE_POINT, 0, 0, 0, 0, 1'b0);
		send_prim(MODE_POINT, 'h7FFFFF, 0, 0, 0, 1'b0);
		send_prim(MODE_POINT, -'h800000, 0, 0, 0, 1'b0);
		send_prim(MODE_POINT, 'h7FFFFF, 'h7FFFFF, 'h7FFFFF, 0, 1'b1);
		send_prim(MODE_POINT, -'h800000, -'h800000, -'h800000, 0, 1'b0);
		send_prim(MODE_POINT, -BOX_H, 0, 0, 0, 1'b0);
		send_prim(MODE_POINT, 1, 1, 1, 'h7FFFFF, 1'b1);
		send_prim(MODE_SPHERE, 0, 0, 0, 0, 1'b0);
		send_prim(MODE_SPHERE, 0, 0, 0, BOX_H, 1'b0);
		send_prim(MODE_SPHERE, 0, 0, 0, BOX_H - 1, 1'b0);
		send_prim(MODE_SPHERE, -BOX_H - 'h100, 0, 0, 'h100, 1'b0);
		send_prim(MODE_SPHERE, -BOX_H - 'h100 + 1, 0, 0, 'h100, 1'b0);
		send_prim(MODE_SPHERE, 0, 0, 0, 'h7FFFFF, 1'b0);
		send_prim(MODE_CUBE, 0, 0, 0, BOX_H - 1, 1'b0);
		send_prim(MODE_CUBE, 0, 0, 0, BOX_H, 1'b0);
		send_prim(MODE_CUBE, -2 * BOX_H, 0, 0, BOX_H, 1'b0);
		send_prim(MODE_CUBE, -'h800000, -'h800000, -'h800000, 'h7FFFFF, 1'b0);
		send_prim(MODE_POLY, -2 * BOX_H, 0, 0, 0, 1'b0);
		send_prim(MODE_POINT, 0, 0, 0, 0, 1'b0);
		send_prim(MODE_POLY, 2 * BOX_H, 0, 0, 0, 1'b0);
		send_prim(MODE_POLY, 0, 2 * BOX_H, 0, 0, 1'b1);
		send_prim(MODE_POLY, 0, 0, 0, 'h7FFFFF, 1'b1);
		send_prim(MODE_POLY, 2 * BOX_H, 0, 0, 0, 1'b0);
		send_prim(MODE_POLY, 3 * BOX_H, BOX_H / 2, 0, 0, 1'b1);
		run_random(200);
		hold_until_drained();

		span = 'h8000;
		set_box('h8000, 1'b1);
		load_planes();
		run_random(150);
		hold_until_drained();

		span = 'h3FFFFF;
		set_uniform(pack_plane('h7FF, 'h7FF, 'h7FF, 'h7FFFFFF));
		load_planes();
		run_random(80);
		hold_until_drained();

		set_uniform(pack_plane(-'h800, -'h800, -'h800, -'h8000000));
		load_planes();
		run_random(80);
		hold_until_drained();

		span = 'h100000;
		for (int i = 0; i < NUM_PLANES; i++)
			plane_cfg[i] = {$urandom(), $urandom()};
		load_planes();
		run_random(100);
		hold_until_drained();

		span = 'h3FFFFF;
		set_box('h7FFFFF, 1'b0);
		load_planes();
		run_random(150);
		hold_until_drained();

		span = BOX_H;
		set_uniform('1);
		load_planes();
		run_random(50);
		hold_until_drained();

		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/vfc_pkg.sv
hw/rtl/vfc_cell.sv
hw/rtl/vfc_out.sv
hw/rtl/view_frustum_cull_test.sv
verif/tb_view_frustum_cull_test.sv
